// ===== hw/rtl/utf8v_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 text validator package
// Register indexes, byte classes and the codepoint rejection rule.
// ----------------------------------------------------------------------------
package utf8v_pkg;

	localparam int unsigned CFG_ADDR_W = 4;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [1:0] REG_IDENTITY_MODE = 2'd0;
	localparam logic [1:0] REG_MAX_BYTES     = 2'd1;
	localparam logic [1:0] REG_ALLOW_EMPTY   = 2'd2;

	localparam logic [11:0] MAX_BYTES_RESET = 12'd4095;
	localparam int unsigned MAX_BYTES_TOP   = 4095;

	localparam int unsigned CP_W = 21;

	localparam logic [7:0] LEAD2_LO   = 8'hC2;
	localparam logic [7:0] LEAD2_HI   = 8'hDF;
	localparam logic [7:0] LEAD3_LO   = 8'hE0;
	localparam logic [7:0] LEAD3_HI   = 8'hEF;
	localparam logic [7:0] LEAD4_LO   = 8'hF0;
	localparam logic [7:0] LEAD4_HI   = 8'hF4;
	localparam logic [7:0] ASCII_TOP  = 8'h7F;
	localparam logic [1:0] CONT_MARK  = 2'b10;

	localparam logic [1:0] CLS_ONE   = 2'd0;
	localparam logic [1:0] CLS_TWO   = 2'd1;
	localparam logic [1:0] CLS_THREE = 2'd2;
	localparam logic [1:0] CLS_FOUR  = 2'd3;

	localparam logic [CP_W-1:0] CP_SPACE = 21'h00020;
	localparam logic [CP_W-1:0] CP_TAB   = 21'h00009;

	function automatic logic cp_rejected(input logic [CP_W-1:0] cp, input logic [1:0] cls);
		logic [CP_W-1:0] min_cp;
		logic            bad;
		begin
			case (cls)
				CLS_ONE:   min_cp = 21'h000000;
				CLS_TWO:   min_cp = 21'h000080;
				CLS_THREE: min_cp = 21'h000800;
				CLS_FOUR:  min_cp = 21'h010000;
				default:   min_cp = 21'h000000;
			endcase
			bad = (cp < min_cp) || (cp > 21'h10FFFF);
			bad = bad || (cp >= 21'h00D800 && cp <= 21'h00DFFF);
			bad = bad || (cp < 21'h000020);
			bad = bad || (cp >= 21'h00007F && cp <= 21'h00009F);
			bad = bad || (cp >= 21'h00200B && cp <= 21'h00200F);
			bad = bad || (cp >= 21'h002028 && cp <= 21'h00202E);
			bad = bad || (cp >= 21'h002060 && cp <= 21'h00206F);
			bad = bad || (cp == 21'h00FEFF);
			return bad;
		end
	endfunction

endpackage

// ===== hw/rtl/utf8_text_validator.sv =====
// ----------------------------------------------------------------------------
// UTF-8 text validator
// Checks a byte stream string by string for well-formed, printable UTF-8
// within a length limit and gives one pass flag at the end of each string.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// s_*       in         tdata = text_byte, tuser = has_byte, tlast = last_item
// m_*       out        tdata = text_valid, one beat per string
// APB       in/out     identity_mode, max_bytes, allow_empty
//
// One beat per cycle is taken while the input does not stall; a beat is held in
// the input register, and its decode and string state update are done from there.
// The result of a string is registered when its last beat leaves the input register.
// Reset clears the string state and sets registers to their defaults.
// The input stalls only while a finished result is held and the next
// string end waits behind it.
// ----------------------------------------------------------------------------
module utf8_text_validator #(
	parameter int unsigned LENGTH_LIMIT = 4095
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [utf8v_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [utf8v_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [utf8v_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                                 pready,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [7:0]                           s_tdata,  // [7:0] text_byte
	input  logic [0:0]                           s_tuser,  // [0] has_byte
	input  logic                                 s_tlast,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [7:0]                           m_tdata   // [0] text_valid, rest zero
);
	import utf8v_pkg::*;

	localparam int unsigned TOP   = (LENGTH_LIMIT > MAX_BYTES_TOP) ? LENGTH_LIMIT : MAX_BYTES_TOP;
	localparam int unsigned CAP   = TOP + 1;
	localparam int unsigned CNT_W = $clog2(CAP + 1);
	localparam logic [CNT_W-1:0] CNT_CAP   = CNT_W'(CAP);
	localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(LENGTH_LIMIT);

	logic        identity_mode_q;
	logic [11:0] max_bytes_q;
	logic        allow_empty_q;
	logic [1:0]  reg_idx;
	logic        cfg_wr;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        has_s1;
	logic        last_s1;
	logic        proc_go;

	logic [1:0]      pend_q, n_pend;
	logic [CP_W-1:0] part_q, n_part;
	logic [1:0]      lead_q, n_lead;
	logic [CNT_W-1:0] cnt_q, n_cnt;
	logic            fail_q, n_fail;
	logic            nonsp_q, n_nonsp;
	logic            fin;
	logic [CP_W-1:0] fin_cp;
	logic [1:0]      fin_cls;
	logic [CNT_W-1:0] limit;
	logic            ok;
	logic            text_valid_q;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			identity_mode_q <= 1'b0;
			max_bytes_q     <= MAX_BYTES_RESET;
			allow_empty_q   <= 1'b0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_IDENTITY_MODE: identity_mode_q <= pwdata[0];
				REG_MAX_BYTES:     max_bytes_q     <= pwdata[11:0];
				REG_ALLOW_EMPTY:   allow_empty_q   <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_IDENTITY_MODE: prdata = {31'd0, identity_mode_q};
			REG_MAX_BYTES:     prdata = {20'd0, max_bytes_q};
			REG_ALLOW_EMPTY:   prdata = {31'd0, allow_empty_q};
			default:           prdata = '0;
		endcase
	end

	assign proc_go  = valid_s1 && (!last_s1 || !m_tvalid || m_tready);
	assign s_tready = !valid_s1 || proc_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			has_s1  <= s_tuser[0];
			last_s1 <= s_tlast;
		end
	end

	always_comb begin
		n_pend  = pend_q;
		n_part  = part_q;
		n_lead  = lead_q;
		n_cnt   = cnt_q;
		n_fail  = fail_q;
		n_nonsp = nonsp_q;
		fin     = 1'b0;
		fin_cp  = part_q;
		fin_cls = lead_q;
		if (has_s1) begin
			if (cnt_q != CNT_CAP) begin
				n_cnt = cnt_q + 1'b1;
			end
			if (!fail_q) begin
				if (pend_q != 2'd0) begin
					if (byte_s1[7:6] != CONT_MARK) begin
						n_fail = 1'b1;
					end else begin
						fin_cp = {part_q[CP_W-7:0], byte_s1[5:0]};
						n_part = fin_cp;
						n_pend = pend_q - 2'd1;
						fin    = (pend_q == 2'd1);
					end
				end else if (byte_s1 <= ASCII_TOP) begin
					fin     = 1'b1;
					fin_cp  = {13'd0, byte_s1};
					fin_cls = CLS_ONE;
				end else if (byte_s1 inside {[LEAD2_LO:LEAD2_HI]}) begin
					n_part = {16'd0, byte_s1[4:0]};
					n_lead = CLS_TWO;
					n_pend = 2'd1;
				end else if (byte_s1 inside {[LEAD3_LO:LEAD3_HI]}) begin
					n_part = {17'd0, byte_s1[3:0]};
					n_lead = CLS_THREE;
					n_pend = 2'd2;
				end else if (byte_s1 inside {[LEAD4_LO:LEAD4_HI]}) begin
					n_part = {18'd0, byte_s1[2:0]};
					n_lead = CLS_FOUR;
					n_pend = 2'd3;
				end else begin
					n_fail = 1'b1;
				end
				if (fin) begin
					if (cp_rejected(fin_cp, fin_cls)) begin
						n_fail = 1'b1;
					end else if (fin_cp != CP_SPACE && fin_cp != CP_TAB) begin
						n_nonsp = 1'b1;
					end
					n_part = '0;
					n_lead = CLS_ONE;
				end
			end
		end
	end

	always_comb begin
		limit = identity_mode_q ? CNT_W'(max_bytes_q) : CNT_LIMIT;
		ok    = !n_fail && (n_pend == 2'd0) && (n_cnt <= limit);
		if (identity_mode_q) begin
			if (n_cnt == '0) begin
				ok = ok && allow_empty_q;
			end else begin
				ok = ok && n_nonsp;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= '0;
			part_q  <= '0;
			lead_q  <= '0;
			cnt_q   <= '0;
			fail_q  <= 1'b0;
			nonsp_q <= 1'b0;
		end else if (proc_go) begin
			if (last_s1) begin
				pend_q  <= '0;
				part_q  <= '0;
				lead_q  <= '0;
				cnt_q   <= '0;
				fail_q  <= 1'b0;
				nonsp_q <= 1'b0;
			end else begin
				pend_q  <= n_pend;
				part_q  <= n_part;
				lead_q  <= n_lead;
				cnt_q   <= n_cnt;
				fail_q  <= n_fail;
				nonsp_q <= n_nonsp;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (proc_go && last_s1) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc_go && last_s1) begin
			text_valid_q <= ok;
		end
	end

	assign m_tdata = {7'd0, text_valid_q};

	a_clear_after_end: assert property (@(posedge clk) disable iff (!arst_n)
		proc_go && last_s1 |=> pend_q == 2'd0 && cnt_q == '0 && !fail_q && !nonsp_q)
		else $error("string state not cleared after the last beat");

	a_pend_within_lead: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd0 |-> lead_q != CLS_ONE && pend_q <= lead_q)
		else $error("pending continuations exceed the lead class");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_CAP)
		else $error("byte counter passed its saturation value");

	a_result_from_end: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(valid_s1 && last_s1))
		else $error("result beat without a string end");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready && valid_s1 && last_s1 |-> !proc_go)
		else $error("held result would be overwritten");

endmodule
